[hdl/rrs_pkg.sv]
`timescale 1ns / 1ps

package rrs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 8;
  localparam int TIME_W      = 16;

  localparam logic [TIME_W-1:0] QUANTUM_RESET = TIME_W'(3);

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_SLICE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_ADDED = 2'd0,
    STAT_RAN   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_SLICE = 1'b1
  } bk_state_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  job_id;
    logic [TIME_W-1:0] burst_time;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] time_left;
  } job_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   slice_job;
    logic [TIME_W-1:0] run_time;
    logic [TIME_W-1:0] time_left;
    logic              finished;
  } res_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

endpackage

[hdl/rrs_front.sv]
`timescale 1ns / 1ps

module rrs_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic                      in_op,
  input  logic [rrs_pkg::ID_W-1:0]  in_job_id,
  input  logic [rrs_pkg::TIME_W-1:0] in_burst_time,
  output logic                      cmd_valid,
  output rrs_pkg::cmd_t             cmd,
  input  logic                      cmd_pop
);
  import rrs_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;
  cmd_t       in_cmd;

  // classify the request
  always_comb begin
    in_cmd.op         = in_op ? OP_SLICE : OP_ADD;
    in_cmd.job_id     = in_job_id;
    in_cmd.burst_time = in_burst_time;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = entry_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

[hdl/rrs_back.sv]
`timescale 1ns / 1ps

module rrs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [rrs_pkg::TIME_W-1:0] cfg_wdata,
  input  logic                       cmd_valid,
  input  rrs_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  input  logic                       res_full,
  output logic                       res_push,
  output rrs_pkg::res_t              res
);
  import rrs_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  job_t              rd_data_r;
  logic              mem_we;
  job_t              mem_wdata;

  bk_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TIME_W-1:0] quantum_r;

  logic              start;
  logic              q_full, q_empty;
  logic [TIME_W-1:0] run_time, time_left;

  assign start   = cmd_valid && !res_full;
  assign q_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);

  assign run_time  = (rd_data_r.time_left < quantum_r) ? rd_data_r.time_left : quantum_r;
  assign time_left = rd_data_r.time_left - run_time;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (start && cmd.op == OP_SLICE && !q_empty) begin
          state_nxt = BK_SLICE;
        end
      end
      BK_SLICE: state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '{status: STAT_ADDED, default: '0};
    mem_we    = 1'b0;
    mem_wdata = '{job_id: cmd.job_id, time_left: cmd.burst_time};
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    unique case (state_r)
      BK_IDLE: begin
        if (start) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_ADD) begin
            res_push = 1'b1;
            if (q_full) begin
              res.status = STAT_FULL;
            end else begin
              res.status = STAT_ADDED;
              mem_we     = 1'b1;
              tail_nxt   = next_idx(tail_r);
              count_nxt  = count_r + CNT_W'(1);
            end
          end else if (q_empty) begin
            res_push   = 1'b1;
            res.status = STAT_EMPTY;
          end
        end
      end
      BK_SLICE: begin
        // head entry was fetched on the way in
        res_push      = 1'b1;
        res.status    = STAT_RAN;
        res.slice_job = rd_data_r.job_id;
        res.run_time  = run_time;
        res.time_left = time_left;
        head_nxt      = next_idx(head_r);
        if (time_left != '0) begin
          mem_we    = 1'b1;
          mem_wdata = '{job_id: rd_data_r.job_id, time_left: time_left};
          tail_nxt  = next_idx(tail_r);
        end else begin
          res.finished = 1'b1;
          count_nxt    = count_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      quantum_r <= QUANTUM_RESET;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        quantum_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= mem_wdata;
    end
    rd_data_r <= mem[head_r];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("job count above depth");

  a_slice_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_SLICE |-> !q_empty)
    else $error("slice on empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_IDLE && q_full) |-> !mem_we)
    else $error("write into full job queue");

  a_slice_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_SLICE |=> state_r == BK_IDLE && $past(res_push))
    else $error("slice did not complete in one cycle");

endmodule

[hdl/rrs_outq.sv]
`timescale 1ns / 1ps

module rrs_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_push,
  input  rrs_pkg::res_t res,
  output logic          res_full,
  output logic          out_empty,
  input  logic          out_pop,
  output rrs_pkg::res_t out_res
);
  import rrs_pkg::*;

  res_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign res_full  = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign out_res   = entry_r[rd_ptr_r];
  assign do_push   = res_push && !res_full;
  assign do_pop    = out_pop && !out_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= res;
    end
  end

endmodule

[hdl/round_robin_slice_scheduler.sv]
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     in_push / in_full    in_op, in_job_id, in_burst_time
// result    out_pop / out_empty  out_status, out_slice_job, out_run_time,
//                                out_time_left, out_finished
// config    cfg_we               cfg_wdata (quantum)
//
// Add request: handled in the executor's idle state; slice: job memory read,
// then compute and write back to the tail if time remains. No new request is
// taken while a slice is in progress; requests and results are registered in queues.
// Synchronous active-low reset empties both queues and the job FIFO and
// loads quantum with 3. Two-entry request and result queues let input and
// output stall independently; the executor waits while the result queue is full.

module round_robin_slice_scheduler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [rrs_pkg::TIME_W-1:0] cfg_wdata,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic                       in_op,
  input  logic [rrs_pkg::ID_W-1:0]   in_job_id,
  input  logic [rrs_pkg::TIME_W-1:0] in_burst_time,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [1:0]                 out_status,
  output logic [rrs_pkg::ID_W-1:0]   out_slice_job,
  output logic [rrs_pkg::TIME_W-1:0] out_run_time,
  output logic [rrs_pkg::TIME_W-1:0] out_time_left,
  output logic                       out_finished
);
  import rrs_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  logic res_push, res_full;
  res_t res, out_res;

  rrs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_job_id     (in_job_id),
    .in_burst_time (in_burst_time),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  rrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  rrs_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

  assign out_status    = out_res.status;
  assign out_slice_job = out_res.slice_job;
  assign out_run_time  = out_res.run_time;
  assign out_time_left = out_res.time_left;
  assign out_finished  = out_res.finished;

endmodule
